// ===== hdl/size_class_slab_allocator_defines.svh =====
// Assertion macros shared by the allocator RTL.
// SCSA_ASSERT checks a consequent in the same cycle as its antecedent.
// SCSA_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define SCSA_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SCSA_ASSERT(label, clk, rst_n, ante, cons)
`define SCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/scsa_pkg.sv =====
package scsa_pkg;

    // Field widths of the two channels.
    localparam int SIZE_W   = 16;
    localparam int ADDR_W   = 19;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 4;

    // Slab geometry: 16-byte class step, 64 classes up to 1024 bytes,
    // 64 KiB chunks, 8 chunks in the pool.
    localparam int STEP_SHIFT     = 4;
    localparam int MAX_SLAB_BYTES = 1024;
    localparam int NUM_CLASSES    = 64;
    localparam int CLS_W          = 6;
    localparam int SLOT_W         = 15;
    localparam int NUM_SLOTS      = 32768;
    localparam int HEAD_W         = 16;
    localparam int CHUNK_IDX_W    = 3;
    localparam int OFF_W          = 13;
    localparam int POOL_CHUNKS    = 8;

    // Granules of 16 bytes (1 << STEP_SHIFT) in one chunk.
    localparam logic [OFF_W-1:0] CHUNK_GRANULES = 13'd4096;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PASS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOCHUNK = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLASS,
        S_LINK,
        S_EMIT
    } t_state;

    // One entry of the per-class state memory.
    // head:  0 for an empty free list, else slot index plus one.
    // chunk: chunk that the class is currently carving from.
    // off:   granule offset of the next uncarved slot inside that chunk.
    typedef struct packed {
        logic [HEAD_W-1:0]      head;
        logic [CHUNK_IDX_W-1:0] chunk;
        logic [OFF_W-1:0]       off;
    } t_class_entry;

endpackage

// ===== hdl/size_class_slab_allocator.sv =====
// Size-class slab allocator over a 512 KiB pool of eight 64 KiB chunks.
// Input channel (i_in_valid / o_in_ready) carries one word per request: an
// allocate or a free, a byte size and, for a free, a 16-byte aligned slot
// offset. The output channel (o_out_valid / i_out_ready) returns exactly one
// word per request: the slot offset, a status, a new-chunk flag and the
// number of chunks carved so far.
// A request is taken only while the sequencer is idle. A free, an allocate
// served from the bump pointer or a fresh chunk, an allocate that finds the
// pool exhausted, and any out-of-range size are resolved in S_CLASS. An
// allocate served from a free list also passes through S_LINK, because the
// link word of the popped slot comes from the single-port link memory in the
// cycle after the class entry. A new request is taken only after the current
// one has left the sequencer, so class-state read-modify-writes never overlap.
// The result sits in an output register, so a new request is accepted while
// an earlier result waits; if the receiver stalls and that register is full,
// the finished result is held internally until it can move.
// Reset empties all free lists and bump pointers through one valid bit per
// class and sets the chunk count to zero; no clearing pass is needed. Link
// memory contents are never read before being written.
module size_class_slab_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [scsa_pkg::SIZE_W-1:0]     i_size_bytes,
    input  logic [scsa_pkg::ADDR_W-1:0]     i_free_addr,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [scsa_pkg::ADDR_W-1:0]     o_addr,
    output logic [scsa_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_new_chunk,
    output logic [scsa_pkg::CNT_W-1:0]      o_chunks_used
);

`include "size_class_slab_allocator_defines.svh"

    // Sequencer state.
    scsa_pkg::t_state r_state, n_state;

    // Captured request.
    logic                              r_cmd;
    logic                              r_pass;
    logic [scsa_pkg::CLS_W-1:0]        r_cls;
    logic [scsa_pkg::SLOT_W-1:0]       r_fidx;

    // Allocator status.
    logic [scsa_pkg::CNT_W-1:0]        r_chunk_count;
    logic [scsa_pkg::NUM_CLASSES-1:0]  r_cls_valid;
    scsa_pkg::t_class_entry            r_entry;

    // Pending result, held while it waits for the output register.
    logic [scsa_pkg::ADDR_W-1:0]       r_res_addr;
    logic [scsa_pkg::STATUS_W-1:0]     r_res_status;
    logic                              r_res_new;
    logic [scsa_pkg::CNT_W-1:0]        r_res_chunks;

    // Output register.
    logic                              r_out_valid;
    logic [scsa_pkg::ADDR_W-1:0]       r_out_addr;
    logic [scsa_pkg::STATUS_W-1:0]     r_out_status;
    logic                              r_out_new;
    logic [scsa_pkg::CNT_W-1:0]        r_out_chunks;

    // Memories and their registered read data.
    scsa_pkg::t_class_entry            m_class [scsa_pkg::NUM_CLASSES];
    logic [scsa_pkg::HEAD_W-1:0]       m_link  [scsa_pkg::NUM_SLOTS];
    scsa_pkg::t_class_entry            r_cls_rdata;
    logic [scsa_pkg::HEAD_W-1:0]       r_link_rdata;

    // Combinational datapath.
    logic                              accept;
    logic                              out_free;
    logic [scsa_pkg::SIZE_W-1:0]       size_m1;
    logic [scsa_pkg::CLS_W-1:0]        n_cls;
    logic                              n_pass;
    scsa_pkg::t_class_entry            cur;
    logic [scsa_pkg::CLS_W:0]          cls_granules;
    logic [scsa_pkg::OFF_W:0]          off_sum;
    logic                              bump_ok;
    logic [scsa_pkg::SLOT_W-1:0]       pop_idx;
    logic                              is_pop;
    logic                              is_carve;
    logic                              cls_we;
    scsa_pkg::t_class_entry            cls_wdata;
    logic                              link_we;
    logic                              link_re;
    logic                              res_valid;
    logic [scsa_pkg::ADDR_W-1:0]       res_addr;
    logic [scsa_pkg::STATUS_W-1:0]     res_status;
    logic                              res_new;
    logic [scsa_pkg::CNT_W-1:0]        res_chunks;

    assign o_in_ready    = (r_state == scsa_pkg::S_IDLE);
    assign accept        = i_in_valid && o_in_ready;
    assign out_free      = !r_out_valid || i_out_ready;

    // Class index is ceil(size / 16) - 1, taken from size - 1.
    assign size_m1       = i_size_bytes - 16'd1;
    assign n_cls         = size_m1[9:4];
    assign n_pass        = (i_size_bytes == '0) ||
                           (i_size_bytes > 16'(scsa_pkg::MAX_SLAB_BYTES));

    // A class that was never written reads as an empty list with its chunk
    // used up, so the first allocate carves.
    assign cur           = r_cls_valid[r_cls] ? r_cls_rdata :
                           scsa_pkg::t_class_entry'{head: '0, chunk: '0,
                                                    off: scsa_pkg::CHUNK_GRANULES};
    assign cls_granules  = {1'b0, r_cls} + 7'd1;
    assign off_sum       = {1'b0, cur.off} + 14'(cls_granules);
    assign bump_ok       = off_sum <= {1'b0, scsa_pkg::CHUNK_GRANULES};
    assign pop_idx       = 15'(cur.head - 16'd1);

    assign is_pop        = !r_pass && (r_cmd == scsa_pkg::CMD_ALLOC) && (cur.head != '0);
    assign is_carve      = !r_pass && (r_cmd == scsa_pkg::CMD_ALLOC) && (cur.head == '0) &&
                           !bump_ok && (r_chunk_count < 4'(scsa_pkg::POOL_CHUNKS));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scsa_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = scsa_pkg::S_CLASS;
                end
            end
            scsa_pkg::S_CLASS: begin
                if (is_pop) begin
                    n_state = scsa_pkg::S_LINK;
                end else if (out_free) begin
                    n_state = scsa_pkg::S_IDLE;
                end else begin
                    n_state = scsa_pkg::S_EMIT;
                end
            end
            scsa_pkg::S_LINK, scsa_pkg::S_EMIT: begin
                n_state = out_free ? scsa_pkg::S_IDLE : scsa_pkg::S_EMIT;
            end
            default: n_state = scsa_pkg::S_IDLE;
        endcase
    end

    // Memory controls and the result of the current request.
    always_comb begin
        cls_we     = 1'b0;
        cls_wdata  = cur;
        link_we    = 1'b0;
        link_re    = 1'b0;
        res_valid  = 1'b0;
        res_addr   = r_res_addr;
        res_status = r_res_status;
        res_new    = r_res_new;
        res_chunks = r_res_chunks;
        unique case (r_state)
            scsa_pkg::S_CLASS: begin
                res_addr   = '0;
                res_status = scsa_pkg::ST_OK;
                res_new    = 1'b0;
                res_chunks = r_chunk_count;
                res_valid  = !is_pop;
                if (r_pass) begin
                    res_status = scsa_pkg::ST_PASS;
                end else if (r_cmd == scsa_pkg::CMD_FREE) begin
                    // Push: the old head becomes the slot's link.
                    link_we        = 1'b1;
                    cls_we         = 1'b1;
                    cls_wdata.head = {1'b0, r_fidx} + 16'd1;
                end else if (is_pop) begin
                    link_re  = 1'b1;
                    res_addr = {pop_idx, 4'b0};
                end else if (bump_ok) begin
                    cls_we        = 1'b1;
                    cls_wdata.off = off_sum[scsa_pkg::OFF_W-1:0];
                    res_addr      = {cur.chunk, cur.off[11:0], 4'b0};
                end else if (is_carve) begin
                    cls_we          = 1'b1;
                    cls_wdata.chunk = r_chunk_count[scsa_pkg::CHUNK_IDX_W-1:0];
                    cls_wdata.off   = 13'(cls_granules);
                    res_addr        = {r_chunk_count[scsa_pkg::CHUNK_IDX_W-1:0], 16'b0};
                    res_new         = 1'b1;
                    res_chunks      = r_chunk_count + 4'd1;
                end else begin
                    res_status = scsa_pkg::ST_NOCHUNK;
                end
            end
            scsa_pkg::S_LINK: begin
                // Pop completes: the link word becomes the new head.
                cls_we         = 1'b1;
                cls_wdata      = r_entry;
                cls_wdata.head = r_link_rdata;
                res_valid      = 1'b1;
            end
            scsa_pkg::S_EMIT: begin
                res_valid = 1'b1;
            end
            scsa_pkg::S_IDLE: begin
                res_valid = 1'b0;
            end
            default: res_valid = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= scsa_pkg::S_IDLE;
            r_chunk_count <= '0;
            r_cls_valid   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (is_carve && r_state == scsa_pkg::S_CLASS) begin
                r_chunk_count <= r_chunk_count + 4'd1;
            end
            if (cls_we) begin
                r_cls_valid[r_cls] <= 1'b1;
            end
            if (res_valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_pass <= n_pass;
            r_cls  <= n_cls;
            r_fidx <= i_free_addr[scsa_pkg::ADDR_W-1:scsa_pkg::STEP_SHIFT];
        end
        if (r_state == scsa_pkg::S_CLASS) begin
            r_entry      <= cur;
            r_res_addr   <= res_addr;
            r_res_status <= res_status;
            r_res_new    <= res_new;
            r_res_chunks <= res_chunks;
        end
        if (res_valid && out_free) begin
            r_out_addr   <= res_addr;
            r_out_status <= res_status;
            r_out_new    <= res_new;
            r_out_chunks <= res_chunks;
        end
    end

    // Per-class state memory.
    always_ff @(posedge i_clk) begin
        if (cls_we) begin
            m_class[r_cls] <= cls_wdata;
        end
        if (accept) begin
            r_cls_rdata <= m_class[n_cls];
        end
    end

    // Free-list link memory, one word per 16-byte slot.
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            m_link[r_fidx] <= cur.head;
        end
        if (link_re) begin
            r_link_rdata <= m_link[pop_idx];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_addr        = r_out_addr;
    assign o_status      = r_out_status;
    assign o_new_chunk   = r_out_new;
    assign o_chunks_used = r_out_chunks;

    // A fresh chunk is always reported at a chunk boundary with status ok.
    `SCSA_ASSERT(a_new_chunk_base, i_clk, i_rst_n, o_out_valid && o_new_chunk,
        (o_status == scsa_pkg::ST_OK) && (o_addr[15:0] == 16'd0))
    // Carving advances the chunk count by exactly one.
    `SCSA_ASSERT_NEXT(a_carve_count, i_clk, i_rst_n, (r_state == scsa_pkg::S_CLASS) && is_carve,
        r_chunk_count == $past(r_chunk_count) + 4'd1)
    // The chunk count never passes the pool size.
    `SCSA_ASSERT(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_chunk_count <= 4'(scsa_pkg::POOL_CHUNKS))
    // Out of chunks is only reported once the whole pool is carved.
    `SCSA_ASSERT(a_nochunk_full, i_clk, i_rst_n, o_out_valid && (o_status == scsa_pkg::ST_NOCHUNK),
        o_chunks_used == 4'(scsa_pkg::POOL_CHUNKS))

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Widths, geometry and codes of the block.
    localparam int SIZE_W         = scsa_pkg::SIZE_W;
    localparam int ADDR_W         = scsa_pkg::ADDR_W;
    localparam int STATUS_W       = scsa_pkg::STATUS_W;
    localparam int CNT_W          = scsa_pkg::CNT_W;
    localparam int HEAD_W         = scsa_pkg::HEAD_W;
    localparam int STEP_SHIFT     = scsa_pkg::STEP_SHIFT;
    localparam int MAX_SLAB_BYTES = scsa_pkg::MAX_SLAB_BYTES;
    localparam int NUM_CLASSES    = scsa_pkg::NUM_CLASSES;
    localparam int NUM_SLOTS      = scsa_pkg::NUM_SLOTS;
    localparam int POOL_CHUNKS    = scsa_pkg::POOL_CHUNKS;
    localparam logic CMD_ALLOC    = scsa_pkg::CMD_ALLOC;
    localparam logic CMD_FREE     = scsa_pkg::CMD_FREE;
    localparam logic [STATUS_W-1:0] ST_OK      = scsa_pkg::ST_OK;
    localparam logic [STATUS_W-1:0] ST_PASS    = scsa_pkg::ST_PASS;
    localparam logic [STATUS_W-1:0] ST_NOCHUNK = scsa_pkg::ST_NOCHUNK;

    // Byte size of one pool chunk, and the number of random request words.
    localparam int CHUNK_BYTES  = int'(scsa_pkg::CHUNK_GRANULES) << STEP_SHIFT;
    localparam int RANDOM_WORDS = 1730;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;

    // One result word as the block should return it.
    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
        logic                new_chunk;
        logic [CNT_W-1:0]    chunks_used;
    } t_slab_grant;

    // A slot that the testbench believes is currently allocated, with its class.
    typedef struct {
        logic [ADDR_W-1:0] addr;
        int                cls;
    } t_held_block;

    // The scoreboard keeps its own copy of the free lists, bump pointers and
    // chunk count. Every accepted request word is run through that copy and
    // the resulting grant is queued; result words are checked in order.
    class t_slab_scoreboard;
        bit [HEAD_W-1:0]  list_head [0:NUM_CLASSES];
        bit [HEAD_W-1:0]  slot_link [NUM_SLOTS];
        int unsigned      bump_next [0:NUM_CLASSES];
        int unsigned      bump_left [0:NUM_CLASSES];
        bit [CNT_W-1:0]   chunk_count;
        t_slab_grant      grant_q[$];
        int               fail_count;
        int               n_requests, n_frees, n_passes, n_pops, n_carves, n_dry;

        function t_slab_grant predict_grant(logic cmd, logic [SIZE_W-1:0] size,
                                            logic [ADDR_W-1:0] faddr);
            t_slab_grant g;
            int unsigned cls, slot_bytes, idx;
            g = '0;
            n_requests++;
            if (size == 0 || size > MAX_SLAB_BYTES) begin
                // Outside the slab range: reported and otherwise ignored.
                g.status = ST_PASS;
                n_passes++;
            end else begin
                cls = (int'(size) + (1 << STEP_SHIFT) - 1) >> STEP_SHIFT;
                slot_bytes = cls << STEP_SHIFT;
                if (cmd == CMD_FREE) begin
                    // Low address bits are dropped; no check of class or state.
                    idx = 32'(faddr) >> STEP_SHIFT;
                    slot_link[idx] = list_head[cls];
                    list_head[cls] = HEAD_W'(idx + 1);
                    n_frees++;
                end else if (list_head[cls] != 0) begin
                    idx = 32'(list_head[cls]) - 1;
                    list_head[cls] = slot_link[idx];
                    g.addr = ADDR_W'(idx << STEP_SHIFT);
                    n_pops++;
                end else if (bump_left[cls] != 0) begin
                    g.addr = ADDR_W'(bump_next[cls]);
                    bump_next[cls] = bump_next[cls] + slot_bytes;
                    bump_left[cls] = bump_left[cls] - 1;
                end else if (chunk_count >= POOL_CHUNKS) begin
                    g.status = ST_NOCHUNK;
                    n_dry++;
                end else begin
                    g.addr = ADDR_W'(chunk_count * CHUNK_BYTES);
                    g.new_chunk = 1'b1;
                    bump_next[cls] = chunk_count * CHUNK_BYTES + slot_bytes;
                    bump_left[cls] = CHUNK_BYTES / slot_bytes - 1;
                    chunk_count = chunk_count + 1'b1;
                    n_carves++;
                end
            end
            g.chunks_used = chunk_count;
            grant_q.insert(grant_q.size(), g);
            return g;
        endfunction

        function void check_grant(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] status,
                                  logic new_chunk, logic [CNT_W-1:0] chunks_used);
            t_slab_grant want;
            if (grant_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: result word with no request outstanding: addr %h status %0d",
                             $time, addr, status);
                return;
            end
            want = grant_q.pop_front();
            if (addr !== want.addr || status !== want.status ||
                    new_chunk !== want.new_chunk || chunks_used !== want.chunks_used) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: mismatch: addr %h status %0d new_chunk %0d chunks %0d, %s",
                             $time, addr, status, new_chunk, chunks_used,
                             $sformatf("expected addr %h status %0d new_chunk %0d chunks %0d",
                                       want.addr, want.status, want.new_chunk,
                                       want.chunks_used));
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                i_cmd         = CMD_ALLOC;
    logic [SIZE_W-1:0]   i_size_bytes  = '0;
    logic [ADDR_W-1:0]   i_free_addr   = '0;
    logic                i_out_ready   = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [ADDR_W-1:0]   o_addr;
    logic [STATUS_W-1:0] o_status;
    logic                o_new_chunk;
    logic [CNT_W-1:0]    o_chunks_used;

    t_slab_scoreboard sb;
    t_held_block      held_blocks[$];
    bit               calm = 1'b0;
    int               hot_cls[6] = '{1, 2, 17, 48, 63, 64};

    size_class_slab_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_size_bytes  (i_size_bytes),
        .i_free_addr   (i_free_addr),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_addr        (o_addr),
        .o_status      (o_status),
        .o_new_chunk   (o_new_chunk),
        .o_chunks_used (o_chunks_used)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Both sides idle for a random gap before each word, except in calm stretches where
    // they run back to back so the block sees its full rate.
    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // A random byte size that rounds up to the given class.
    function automatic logic [SIZE_W-1:0] class_size(int cls);
        return SIZE_W'((cls - 1) * (1 << STEP_SHIFT) + $urandom_range(1, 1 << STEP_SHIFT));
    endfunction

    // Presents one request word and returns at the edge where it is taken.
    // Valid is only lowered when a gap follows, so a back-to-back word never
    // sees valid dropped and raised in the same time step.
    task automatic send_word(input logic cmd, input logic [SIZE_W-1:0] size,
                             input logic [ADDR_W-1:0] faddr);
        int          gap;
        t_slab_grant g;
        t_held_block hb;
        gap = draw_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_size_bytes <= size;
        i_free_addr  <= faddr;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        g = sb.predict_grant(cmd, size, faddr);
        // Remember granted slots so that the random part can free real blocks.
        if (cmd == CMD_ALLOC && g.status == ST_OK) begin
            hb.addr = g.addr;
            hb.cls  = (int'(size) + 15) >> STEP_SHIFT;
            held_blocks.insert(held_blocks.size(), hb);
        end
    endtask

    // Result side: take words with random stalls and check each one.
    initial begin : result_side
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            sb.check_grant(o_addr, o_status, o_new_chunk, o_chunks_used);
        end
    end

    // Request side: reset, a directed opening, then the random body.
    initial begin : request_side
        int          n, pick, cls, k, kind, w;
        t_held_block blk;
        logic [ADDR_W-1:0] a;
        logic [SIZE_W-1:0] sz;
        sb = new;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sizes outside the slab range, for both commands.
        send_word(CMD_ALLOC, 16'd0, 19'd0);
        send_word(CMD_FREE, 16'd0, 19'h7FFFF);
        send_word(CMD_ALLOC, 16'd1025, 19'd0);
        send_word(CMD_FREE, 16'hFFFF, 19'd0);
        // First allocate of the smallest class carves chunk zero; the next
        // one comes from the bump pointer.
        send_word(CMD_ALLOC, 16'd1, 19'd0);
        send_word(CMD_ALLOC, 16'd16, 19'd0);
        // Largest class carves the next chunk, then bumps by 1024 bytes.
        send_word(CMD_ALLOC, 16'd1024, 19'd0);
        send_word(CMD_ALLOC, 16'd1009, 19'd0);
        // An unaligned free drops its low bits; the allocate pops the slot.
        send_word(CMD_FREE, 16'd5, 19'd25);
        send_word(CMD_ALLOC, 16'd3, 19'd0);
        // The topmost slot goes onto the largest class's list; the allocate is one class lower and carves.
        send_word(CMD_FREE, 16'd1024, 19'h7FFFF);
        send_word(CMD_ALLOC, 16'd1000, 19'd0);
        // A slot of the largest class freed twice into the smallest class:
        // the second free links the slot to itself, so it pops twice.
        send_word(CMD_FREE, 16'd1, 19'h10000);
        send_word(CMD_FREE, 16'd1, 19'h10000);
        send_word(CMD_ALLOC, 16'd1, 19'd0);
        send_word(CMD_ALLOC, 16'd16, 19'd0);
        // A second class carves its own chunk; a free at offset zero is a
        // valid list entry and pops back out before the bump pointer moves.
        send_word(CMD_ALLOC, 16'd17, 19'd0);
        send_word(CMD_FREE, 16'd32, 19'd0);
        send_word(CMD_ALLOC, 16'd32, 19'd0);
        send_word(CMD_ALLOC, 16'd32, 19'd0);

        // Random body. Early on the largest class is favored so its chunk runs
        // dry and another is carved; stray sizes then use up the pool, after
        // which allocates live on the free lists and leftover bump space.
        for (n = 0; n < RANDOM_WORDS; n++) begin
            calm = ((n / 120) % 4) == 2;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                sz = $urandom_range(0, 1) ? 16'd0
                                          : SIZE_W'($urandom_range(MAX_SLAB_BYTES + 1, 65535));
                send_word(1'($urandom_range(0, 1)), sz, ADDR_W'($urandom));
            end else if (pick < 12) begin
                // Free of an arbitrary pool address with an arbitrary size.
                send_word(CMD_FREE, SIZE_W'($urandom_range(1, MAX_SLAB_BYTES)),
                          ADDR_W'($urandom));
            end else if (pick < (n < 300 ? 75 : 55) || held_blocks.size() == 0) begin
                if (n < 300 && $urandom_range(0, 3) != 0)
                    cls = NUM_CLASSES;
                else if ($urandom_range(0, 9) == 0)
                    cls = $urandom_range(1, NUM_CLASSES);
                else
                    cls = hot_cls[$urandom_range(0, 5)];
                send_word(CMD_ALLOC, class_size(cls), ADDR_W'($urandom));
            end else begin
                // Release a held block: mostly a clean free with some other
                // size of the same class, sometimes a wrong class, sometimes
                // a block that stays held and is freed again later.
                k = $urandom_range(0, held_blocks.size() - 1);
                blk = held_blocks[k];
                kind = $urandom_range(0, 9);
                a = blk.addr;
                sz = class_size(blk.cls);
                if (kind == 0)
                    sz = SIZE_W'($urandom_range(1, MAX_SLAB_BYTES));
                if (kind != 1)
                    held_blocks.delete(k);
                if ($urandom_range(0, 3) == 0)
                    a[STEP_SHIFT-1:0] = STEP_SHIFT'($urandom);
                send_word(CMD_FREE, sz, a);
            end
        end
        i_in_valid <= 1'b0;

        // Let the last results come out, then give stray words time to show.
        for (w = 0; w < 4000 && sb.grant_q.size() != 0; w++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.grant_q.size() != 0) begin
            $display("%0d expected result words never arrived", sb.grant_q.size());
            sb.fail_count += sb.grant_q.size();
        end

        $display("Sent %0d request words: %0d frees, %0d out-of-range sizes, %0d list pops.",
                 sb.n_requests, sb.n_frees, sb.n_passes, sb.n_pops);
        $display("Carved %0d chunks; %0d allocates found the pool exhausted; %0d mismatches.",
                 sb.n_carves, sb.n_dry, sb.fail_count);
        if (sb.fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
